// ----- rtl/hcb_pkg.sv -----
package hcb_pkg;

  localparam int unsigned MAX_SYMBOLS = 16;
  localparam int unsigned NODE_COUNT  = 2 * MAX_SYMBOLS - 1;
  localparam int unsigned IDX_W       = $clog2(NODE_COUNT + 1);
  localparam int unsigned WEIGHT_W    = 20;

  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic [WEIGHT_W-1:0] wgt_t;

  typedef struct packed {
    logic [15:0] weight;
    logic        last_weight;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  symbol_index;
    logic [14:0] code_bits;
    logic [3:0]  code_length;
    logic        last_code;
  } out_item_t;

  typedef struct packed {
    logic v1;
    logic v2;
    wgt_t w1;
    wgt_t w2;
    idx_t i1;
    idx_t i2;
  } min_pair_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MERGE,
    ST_WALK
  } state_e;

endpackage

// ----- rtl/huffman_code_builder.sv -----
// Loading: one weight per cycle, busy stays low until the closing beat.
// Build: for n symbols, n-1 merges; the merge at node i follows a scan of
// nodes 0..i-1 (one node compared per cycle by the shared two-minimum unit);
// then each code is built by a leaf-to-root walk, one result beat per symbol.
// Results are strobed for one cycle; the receiver cannot stall.
// Reset (async, active low) clears the symbol count, node valid bits and FSM.
module huffman_code_builder import hcb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_i,
  output logic      result_valid_o,
  output out_item_t result_o
);

  state_e state_q, state_d;

  wgt_t weight_q [NODE_COUNT];
  idx_t parent_q [NODE_COUNT];
  idx_t left_q   [NODE_COUNT];
  logic [NODE_COUNT-1:0] pvalid_q;

  idx_t cnt_q, n_q, i_q, j_q, s_q, cur_q;
  logic [3:0]  len_q;
  logic [14:0] bits_q;
  min_pair_t   min_q, min_next;
  logic        valid_q;
  out_item_t   res_q;

  logic accept, close, scan_end, merge_end, walk_done, last_sym;
  logic [IDX_W:0] node_end;
  idx_t par;

  assign accept    = start && (state_q == ST_IDLE);
  assign close     = in_i.last_weight || (cnt_q == idx_t'(MAX_SYMBOLS - 1));
  assign scan_end  = (j_q == i_q - idx_t'(1));
  assign node_end  = {n_q, 1'b0} - (IDX_W+1)'(1);
  assign merge_end = ({1'b0, i_q} + (IDX_W+1)'(1)) == node_end;
  assign par       = parent_q[cur_q];
  assign walk_done = !pvalid_q[cur_q];
  assign last_sym  = (s_q == n_q - idx_t'(1));

  hcb_min2 u_min2 (
    .cur_i      (min_q),
    .cand_ok_i  (!pvalid_q[j_q]),
    .cand_w_i   (weight_q[j_q]),
    .cand_idx_i (j_q),
    .next_o     (min_next)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && close) begin
          state_d = (cnt_q == '0) ? ST_WALK : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_end) state_d = ST_MERGE;
      end
      ST_MERGE: begin
        state_d = merge_end ? ST_WALK : ST_SCAN;
      end
      ST_WALK: begin
        if (walk_done && last_sym) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    busy = (state_q != ST_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      pvalid_q <= '0;
      valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            pvalid_q[cnt_q] <= 1'b0;
            cnt_q           <= cnt_q + idx_t'(1);
          end
        end
        ST_MERGE: begin
          pvalid_q[min_q.i1] <= 1'b1;
          pvalid_q[min_q.i2] <= 1'b1;
          pvalid_q[i_q]      <= 1'b0;
        end
        ST_WALK: begin
          if (walk_done) begin
            valid_q <= 1'b1;
            if (last_sym) begin
              pvalid_q <= '0;
              cnt_q    <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        weight_q[cnt_q] <= WEIGHT_W'(in_i.weight);
        n_q    <= cnt_q + idx_t'(1);
        i_q    <= cnt_q + idx_t'(1);
        j_q    <= '0;
        min_q  <= '0;
        s_q    <= '0;
        cur_q  <= '0;
        len_q  <= '0;
        bits_q <= '0;
      end
      ST_SCAN: begin
        min_q <= min_next;
        j_q   <= j_q + idx_t'(1);
      end
      ST_MERGE: begin
        parent_q[min_q.i1] <= i_q;
        parent_q[min_q.i2] <= i_q;
        left_q[i_q]        <= min_q.i1;
        weight_q[i_q]      <= min_q.w1 + min_q.w2;
        i_q   <= i_q + idx_t'(1);
        j_q   <= '0;
        min_q <= '0;
      end
      ST_WALK: begin
        if (walk_done) begin
          res_q.symbol_index <= s_q[3:0];
          res_q.code_bits    <= bits_q;
          res_q.code_length  <= len_q;
          res_q.last_code    <= last_sym;
          s_q    <= s_q + idx_t'(1);
          cur_q  <= s_q + idx_t'(1);
          len_q  <= '0;
          bits_q <= '0;
        end else begin
          if (left_q[par] != cur_q) bits_q[len_q] <= 1'b1;
          len_q <= len_q + 4'd1;
          cur_q <= par;
        end
      end
      default: ;
    endcase
  end

  assign result_valid_o = valid_q;
  assign result_o       = res_q;

`ifndef SYNTH
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.last_code) |=> !result_valid_o)
    else $error("result beat after last code");
  a_busy_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !result_o.last_code) |-> busy)
    else $error("idle before last code");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= idx_t'(MAX_SYMBOLS))
    else $error("symbol count overflow");
  a_load_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && !close) |=> (!busy && !result_valid_o))
    else $error("result on open set");
`endif

endmodule

// ----- rtl/hcb_min2.sv -----
module hcb_min2 import hcb_pkg::*; (
  input  min_pair_t cur_i,
  input  logic      cand_ok_i,
  input  wgt_t      cand_w_i,
  input  idx_t      cand_idx_i,
  output min_pair_t next_o
);

  always_comb begin
    next_o = cur_i;
    if (cand_ok_i) begin
      if (!cur_i.v1 || cand_w_i < cur_i.w1) begin
        next_o.v2 = cur_i.v1;
        next_o.w2 = cur_i.w1;
        next_o.i2 = cur_i.i1;
        next_o.v1 = 1'b1;
        next_o.w1 = cand_w_i;
        next_o.i1 = cand_idx_i;
      end else if (!cur_i.v2 || cand_w_i < cur_i.w2) begin
        next_o.v2 = 1'b1;
        next_o.w2 = cand_w_i;
        next_o.i2 = cand_idx_i;
      end
    end
  end

endmodule
